FILE: sv/gpd_pkg.sv
// Shared types, constants and helper functions for the gamepad report decoder.
// No dependencies; every other file imports this package.
package gpd_pkg;

  localparam int unsigned StoreDepth = 18;
  localparam int unsigned CntW       = 5;
  localparam int unsigned NumButtons = 17;

  localparam logic [CntW-1:0] CountMax  = 5'd31;
  localparam logic [CntW-1:0] LenStatus = 5'd2;
  localparam logic [CntW-1:0] LenReport = 5'd29;

  localparam logic [7:0] HdrStatus   = 8'h08;
  localparam logic [7:0] StsDisconn  = 8'h00;
  localparam logic [7:0] StsConnA    = 8'h80;
  localparam logic [7:0] StsConnB    = 8'hc0;
  localparam logic [7:0] LedBase     = 8'h40;
  localparam logic [7:0] LedPortOffs = 8'h02;
  localparam logic [7:0] StickCenter = 8'd127;
  localparam logic [2:0] BattReset   = 3'd5;
  localparam logic [7:0] BattStep    = 8'd44;

  // 29-byte report headers, first byte in the top bits
  localparam logic [31:0] HdrAnnounce = 32'h000f00f0;
  localparam logic [31:0] HdrBattery  = 32'h00000013;
  localparam logic [31:0] HdrEvent    = 32'h000100f0;
  localparam logic [15:0] HdrEventTl  = 16'h0013;

  typedef logic [StoreDepth-1:0][7:0] pkt_t;

  // Report waiting for decode: set on the final byte of a report.
  typedef struct packed {
    logic            valid;
    logic [CntW-1:0] len;
  } pend_t;

  // Byte divided by 44, as a count of thresholds passed (result 0..5).
  function automatic logic [2:0] batt_div(input logic [7:0] x);
    logic [2:0] q;
    q = 3'd0;
    if (x >= BattStep)                 q = 3'd1;
    if (x >= 8'(2 * BattStep))         q = 3'd2;
    if (x >= 8'(3 * BattStep))         q = 3'd3;
    if (x >= 8'(4 * BattStep))         q = 3'd4;
    if (x >= 8'(5 * BattStep))         q = 3'd5;
    return q;
  endfunction

  // Signed little-endian 16-bit value / 256 (toward zero) + 128, mod 256.
  function automatic logic [7:0] stick_conv(input logic [7:0] lo, input logic [7:0] hi);
    logic corr;
    corr = hi[7] & (lo != 8'd0);
    return {~hi[7], hi[6:0]} + {7'd0, corr};
  endfunction

endpackage

FILE: sv/gpd_if.sv
// Handshake channel interfaces of the gamepad report decoder.
// Depends on gpd_pkg for field widths.
interface gpd_in_if import gpd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] report_byte;
  logic       last_byte;

  modport source (output valid, report_byte, last_byte, input ready);
  modport sink   (input valid, report_byte, last_byte, output ready);
endinterface

interface gpd_cfg_if import gpd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] port_number;

  modport source (output valid, port_number, input ready);
  modport sink   (input valid, port_number, output ready);
endinterface

interface gpd_out_if import gpd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  handled;
  logic                  attached;
  logic [2:0]            charge_level;
  logic [NumButtons-1:0] button_bits;
  logic [7:0]            left_x;
  logic [7:0]            left_y;
  logic [7:0]            right_x;
  logic [7:0]            right_y;
  logic [7:0]            left_trigger;
  logic [7:0]            right_trigger;
  logic                  led_send;
  logic [7:0]            led_code;

  modport source (output valid, handled, attached, charge_level, button_bits, left_x,
                  left_y, right_x, right_y, left_trigger, right_trigger, led_send,
                  led_code, input ready);
  modport sink   (input valid, handled, attached, charge_level, button_bits, left_x,
                  left_y, right_x, right_y, left_trigger, right_trigger, led_send,
                  led_code, output ready);
endinterface

FILE: sv/gpd_ingest.sv
// Byte intake: counts report bytes, keeps the first eighteen, flags a finished report.
// Depends on gpd_pkg.
module gpd_ingest import gpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] report_byte_i,
  input  logic       last_byte_i,
  input  logic       take_i,
  output pend_t      pend_o,
  output pkt_t       pkt_o
);

  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  pend_t           pend_q, pend_d;
  pkt_t            pkt_q;
  logic            xfer;

  // Stall while a finished report waits and cannot be taken; store must stay intact.
  assign in_ready_o = !pend_q.valid || take_i;
  assign xfer       = in_valid_i && in_ready_o;
  assign cnt_inc    = (cnt_q == CountMax) ? CountMax : cnt_q + 5'd1;

  always_comb begin
    cnt_d  = cnt_q;
    pend_d = pend_q;
    if (take_i) begin
      pend_d.valid = 1'b0;
    end
    if (xfer) begin
      if (last_byte_i) begin
        cnt_d        = '0;
        pend_d.valid = 1'b1;
        pend_d.len   = cnt_inc;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer && (cnt_q < CntW'(StoreDepth))) begin
      pkt_q[cnt_q] <= report_byte_i;
    end
  end

  assign pend_o = pend_q;
  assign pkt_o  = pkt_q;

  a_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && last_byte_i |=> cnt_q == '0 && pend_q.valid)
    else $error("byte count not restarted after final byte");

  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q.valid && !take_i |=> pend_q.valid && $stable(pend_q.len))
    else $error("pending report lost while stalled");

  a_len_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q.valid |-> pend_q.len != '0)
    else $error("pending report has zero length");

endmodule

FILE: sv/gpd_decode.sv
// Report decoder: status, battery and input-event decode, controller state, result register.
// Depends on gpd_pkg.
module gpd_decode import gpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pend_t                 pend_i,
  input  pkt_t                  pkt_i,
  input  logic [1:0]            port_number_i,
  output logic                  take_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  handled_o,
  output logic                  attached_o,
  output logic [2:0]            charge_level_o,
  output logic [NumButtons-1:0] button_bits_o,
  output logic [3:0][7:0]       sticks_o,
  output logic [1:0][7:0]       triggers_o,
  output logic                  led_send_o,
  output logic [7:0]            led_code_o
);

  logic                  valid_q;
  logic                  handled_q, handled_d;
  logic                  att_q, att_d;
  logic [2:0]            batt_q, batt_d;
  logic [NumButtons-1:0] btn_q, btn_d, btn_ev;
  logic [3:0][7:0]       stick_q, stick_d;
  logic [1:0][7:0]       trig_q, trig_d;
  logic                  led_q, led_d;
  logic [7:0]            code_q, code_d;
  logic                  is_status, is_long, hdr_announce, hdr_battery, hdr_event;
  logic [31:0]           head;
  logic [7:0]            d, e;

  // State registers double as the result payload: they only move on a transfer.
  assign take_o = pend_i.valid && (!valid_q || out_ready_i);

  assign head         = {pkt_i[0], pkt_i[1], pkt_i[2], pkt_i[3]};
  assign is_status    = (pend_i.len == LenStatus) && (pkt_i[0] == HdrStatus);
  assign is_long      = (pend_i.len == LenReport);
  assign hdr_announce = head == HdrAnnounce;
  assign hdr_battery  = head == HdrBattery;
  assign hdr_event    = head == HdrEvent && {pkt_i[4], pkt_i[5]} == HdrEventTl;

  assign d = pkt_i[6];
  assign e = pkt_i[7];
  assign btn_ev = {e[2], d[5], d[4], pkt_i[9] != 8'd0, pkt_i[8] != 8'd0, d[7], d[6],
                   e[1], e[0], d[3], d[2], d[1], d[0], e[6], e[7], e[5], e[4]};

  always_comb begin
    handled_d = 1'b0;
    att_d     = att_q;
    batt_d    = batt_q;
    btn_d     = btn_q;
    stick_d   = stick_q;
    trig_d    = trig_q;
    led_d     = 1'b0;
    code_d    = 8'd0;
    if (is_status) begin
      handled_d = 1'b1;
      if (pkt_i[1] == StsDisconn) begin
        btn_d   = '0;
        stick_d = {4{StickCenter}};
        trig_d  = '0;
        att_d   = 1'b0;
      end else if (pkt_i[1] == StsConnA || pkt_i[1] == StsConnB) begin
        led_d  = 1'b1;
        code_d = LedBase + {6'd0, port_number_i} + LedPortOffs;
        att_d  = 1'b1;
      end
    end else if (is_long) begin
      if (hdr_announce) begin
        batt_d = batt_div(pkt_i[17]);
      end else if (hdr_battery) begin
        batt_d = batt_div(pkt_i[4]);
      end else if (hdr_event) begin
        handled_d  = 1'b1;
        btn_d      = btn_ev;
        stick_d[0] = stick_conv(pkt_i[10], pkt_i[11]);
        stick_d[1] = ~stick_conv(pkt_i[12], pkt_i[13]);
        stick_d[2] = stick_conv(pkt_i[14], pkt_i[15]);
        stick_d[3] = ~stick_conv(pkt_i[16], pkt_i[17]);
        trig_d[0]  = pkt_i[8];
        trig_d[1]  = pkt_i[9];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      att_q   <= 1'b0;
      batt_q  <= BattReset;
      btn_q   <= '0;
      stick_q <= {4{StickCenter}};
      trig_q  <= '0;
    end else begin
      if (take_o) begin
        valid_q <= 1'b1;
        att_q   <= att_d;
        batt_q  <= batt_d;
        btn_q   <= btn_d;
        stick_q <= stick_d;
        trig_q  <= trig_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      handled_q <= handled_d;
      led_q     <= led_d;
      code_q    <= code_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign handled_o       = handled_q;
  assign attached_o      = att_q;
  assign charge_level_o  = batt_q;
  assign button_bits_o   = btn_q;
  assign sticks_o        = stick_q;
  assign triggers_o      = trig_q;
  assign led_send_o      = led_q;
  assign led_code_o      = code_q;

  a_led_att: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && led_q |-> att_q && handled_q)
    else $error("LED request without attach");

  a_batt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    batt_q <= 3'd5)
    else $error("battery level out of range");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> $stable(btn_q) && $stable(stick_q) && $stable(att_q))
    else $error("state changed while result stalled");

endmodule

FILE: sv/gamepad_report_decoder.sv
// Gamepad report decoder top level: byte intake, decoder, configuration register.
// Depends on gpd_pkg, gpd_if, gpd_ingest and gpd_decode.
// Throughput: one report byte per cycle while intake is not stalled. The final byte is registered
// at its transfer, and the result register loads once the decoder takes the pending report.
// Back-pressure holds the result; intake stalls only while a finished report waits.
// Reset: port 0, detached, battery 5, sticks 127, buttons and triggers clear; store kept.
module gamepad_report_decoder import gpd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  gpd_cfg_if.sink   cfg_i,
  gpd_in_if.sink    in_i,
  gpd_out_if.source res_o
);

  logic [1:0]      port_q;
  pend_t           pend;
  pkt_t            pkt;
  logic            take;
  logic [3:0][7:0] sticks;
  logic [1:0][7:0] triggers;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_q <= 2'd0;
    end else if (cfg_i.valid) begin
      port_q <= cfg_i.port_number;
    end
  end

  gpd_ingest u_ingest (
    .clk_i,
    .rst_ni,
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .report_byte_i (in_i.report_byte),
    .last_byte_i   (in_i.last_byte),
    .take_i        (take),
    .pend_o        (pend),
    .pkt_o         (pkt)
  );

  gpd_decode u_decode (
    .clk_i,
    .rst_ni,
    .pend_i          (pend),
    .pkt_i           (pkt),
    .port_number_i   (port_q),
    .take_o          (take),
    .out_valid_o     (res_o.valid),
    .out_ready_i     (res_o.ready),
    .handled_o       (res_o.handled),
    .attached_o      (res_o.attached),
    .charge_level_o  (res_o.charge_level),
    .button_bits_o   (res_o.button_bits),
    .sticks_o        (sticks),
    .triggers_o      (triggers),
    .led_send_o      (res_o.led_send),
    .led_code_o      (res_o.led_code)
  );

  assign res_o.left_x        = sticks[0];
  assign res_o.left_y        = sticks[1];
  assign res_o.right_x       = sticks[2];
  assign res_o.right_y       = sticks[3];
  assign res_o.left_trigger  = triggers[0];
  assign res_o.right_trigger = triggers[1];

endmodule
